// ===== src/hfps_pkg.sv =====
// Shared widths, constants, codes and controller/datapath interface types.
package hfps_pkg;

  // Port field widths
  localparam int RATE_W  = 16;
  localparam int TIME_W  = 32;
  localparam int SPEED_W = 16;
  localparam int ANG_W   = 24;
  localparam int PWM_W   = 8;
  localparam int GAIN_W  = 16;
  localparam int REG_IDX_W = 2;

  // Internal widths
  localparam int DIFF_W = SPEED_W + 1;       // right minus left wheel speed
  localparam int ERR_W  = ANG_W + 1;
  localparam int DER_W  = ERR_W + 1;
  localparam int SUM_W  = 32;
  localparam int MA_W   = TIME_W + 1;        // multiplier operand A, signed
  localparam int MB_W   = GAIN_W + 1;        // multiplier operand B, signed
  localparam int PROD_W = MA_W + MB_W;
  localparam int GPROD_W = RATE_W + TIME_W;  // rate * dt fits here, signed
  localparam int ENC_W  = DIFF_W + GAIN_W + 1;
  localparam int Q_W    = 42;                // signed quotient
  localparam int GA_W   = Q_W + 1;           // yaw plus gyro step
  localparam int NUM_W  = 49;                // 49 * angle + encoder term
  localparam int ACC_W  = 52;                // PID sum of products
  localparam int FRAC_W = 16;                // Q8.8 gain times Q?.8 -> /65536
  localparam int CORR_W = ACC_W - FRAC_W + 1;
  localparam int DRV_W  = CORR_W + 2;

  // Constant divider: 13-bit digits, each divided by a reciprocal multiply
  localparam int DIV_W     = 52;
  localparam int DIG_W     = 13;
  localparam int DIV_CYC   = DIV_W / DIG_W;  // digits per division
  localparam int DIV_CNT_W = $clog2(DIV_CYC);
  localparam int DVSR_W    = 11;
  localparam int DX_W      = DVSR_W + DIG_W; // remainder joined with next digit
  localparam int RCP_W     = 30;
  localparam int RCP_SH    = 35;
  localparam int GYRO_DIV  = 1025;
  localparam int HEAD_DIV  = 50;
  // ceil(2^35 / divisor); exact for every partial dividend below 2^24
  localparam logic [RCP_W-1:0] RCP_GYRO = RCP_W'(33521696);
  localparam logic [RCP_W-1:0] RCP_HEAD = RCP_W'(687194768);

  // Register reset values
  localparam logic [GAIN_W-1:0] PROP_RESET  = GAIN_W'(256);
  localparam logic [GAIN_W-1:0] INTEG_RESET = GAIN_W'(0);
  localparam logic [GAIN_W-1:0] DERIV_RESET = GAIN_W'(0);
  localparam logic [GAIN_W-1:0] S2D_RESET   = GAIN_W'(256);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PROP  = 2'd0,
    REG_INTEG = 2'd1,
    REG_DERIV = 2'd2,
    REG_S2D   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MUL_GYRO  = 3'd0,
    MUL_ENC   = 3'd1,
    MUL_PROP  = 3'd2,
    MUL_INTEG = 3'd3,
    MUL_DERIV = 3'd4
  } mul_sel_t;

  typedef enum logic {
    DIV_GYRO = 1'b0,
    DIV_HEAD = 1'b1
  } div_sel_t;

  typedef struct packed {
    logic     accept;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     div_start;
    div_sel_t div_sel;
    logic     ga_load;
    logic     num_load;
    logic     head_load;
    logic     pid_load;
    logic     acc_clr;
    logic     acc_add;
    logic     corr_load;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

// ===== src/hfps_div.sv =====
// Unsigned divider by 1025 or 50: 13-bit digits, reciprocal multiply per digit.
module hfps_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  hfps_pkg::div_sel_t         sel,
  input  logic [hfps_pkg::DIV_W-1:0] dividend,
  output logic                       done,
  output logic [hfps_pkg::DIV_W-1:0] quotient
);
  import hfps_pkg::*;

  logic                    busy;
  logic                    phase;  // 0: multiply, 1: take digit and remainder
  logic [DIV_CNT_W-1:0]    cnt;
  div_sel_t                sel_r;
  logic [DIV_W-1:0]        dvd;    // dividend digits leave at the top, quotient enters below
  logic [DVSR_W-1:0]       rem;
  logic [RCP_W-1:0]        rcp;
  logic [DVSR_W-1:0]       dsr;
  logic [DX_W-1:0]         x;
  logic [DX_W+RCP_W-1:0]   prod;
  logic [DIG_W-1:0]        q_dig;
  logic [DX_W-1:0]         qd;
  logic [DX_W-1:0]         r_full;

  always_comb begin
    case (sel_r)
      DIV_GYRO: begin
        rcp = RCP_GYRO;
        dsr = DVSR_W'(GYRO_DIV);
      end
      DIV_HEAD: begin
        rcp = RCP_HEAD;
        dsr = DVSR_W'(HEAD_DIV);
      end
      default: begin
        rcp = RCP_HEAD;
        dsr = DVSR_W'(HEAD_DIV);
      end
    endcase
  end

  // Remainder stays below the divisor, so each digit quotient fits DIG_W bits
  assign x      = {rem, dvd[DIV_W-1 -: DIG_W]};
  assign q_dig  = prod[RCP_SH+DIG_W-1:RCP_SH];
  assign qd     = DX_W'(q_dig) * DX_W'(dsr);
  assign r_full = x - qd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= '0;
      end else if (busy) begin
        phase <= ~phase;
        if (phase) begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(DIV_CYC - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= dividend;
      rem   <= '0;
      sel_r <= sel;
    end else if (busy) begin
      if (!phase) begin
        prod <= x * rcp;
      end else begin
        dvd <= {dvd[DIV_W-DIG_W-1:0], q_dig};
        rem <= r_full[DVSR_W-1:0];
      end
    end
  end

  assign quotient = dvd;

endmodule

// ===== src/hfps_dp.sv =====
// Datapath: registers, shared multiplier, divider, fusion and PID arithmetic.
module hfps_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  hfps_pkg::ctrl_cmd_t                   cmd,
  output hfps_pkg::dp_status_t                  status,
  input  logic signed [hfps_pkg::RATE_W-1:0]    gyro_rate_raw,
  input  logic [hfps_pkg::TIME_W-1:0]           time_ms,
  input  logic signed [hfps_pkg::SPEED_W-1:0]   speed_left,
  input  logic signed [hfps_pkg::SPEED_W-1:0]   speed_right,
  input  logic signed [hfps_pkg::ANG_W-1:0]     target_heading,
  input  logic [hfps_pkg::PWM_W-1:0]            left_drive_in,
  input  logic [hfps_pkg::PWM_W-1:0]            right_drive_in,
  input  logic                                  wr_en,
  input  logic [hfps_pkg::REG_IDX_W-1:0]        wr_index,
  input  logic [hfps_pkg::GAIN_W-1:0]           wr_data,
  output logic signed [hfps_pkg::ANG_W-1:0]     heading,
  output logic [hfps_pkg::PWM_W-1:0]            left_drive,
  output logic [hfps_pkg::PWM_W-1:0]            right_drive
);
  import hfps_pkg::*;

  localparam logic signed [Q_W-1:0] FUSE_MAX = Q_W'((64'sd1 <<< (ANG_W - 1)) - 1);
  localparam logic signed [Q_W-1:0] FUSE_MIN = Q_W'(-(64'sd1 <<< (ANG_W - 1)));
  localparam logic signed [ANG_W-1:0] ANG_MAX = ANG_W'((64'sd1 <<< (ANG_W - 1)) - 1);
  localparam logic signed [ANG_W-1:0] ANG_MIN = ANG_W'(-(64'sd1 <<< (ANG_W - 1)));
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((64'sd1 <<< (SUM_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-(64'sd1 <<< (SUM_W - 1)));
  localparam logic signed [DRV_W-1:0] PWM_TOP = DRV_W'((1 << PWM_W) - 1);

  // Configuration
  logic [GAIN_W-1:0] prop_gain, integral_gain, deriv_gain, speed_to_degrees;

  // Persistent state
  logic signed [ANG_W-1:0] yaw;
  logic [TIME_W-1:0]       prev_time;
  logic signed [SUM_W-1:0] error_sum;
  logic signed [ERR_W-1:0] prev_err;

  // Per-item registers
  logic signed [RATE_W-1:0] rate_r;
  logic [TIME_W-1:0]        dt_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [ANG_W-1:0]  target_r;
  logic [PWM_W-1:0]         lin_r, rin_r;
  logic signed [PROD_W-1:0] prod;
  logic signed [GA_W-1:0]   ga;
  logic signed [NUM_W-1:0]  num;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [DER_W-1:0]  deriv_r;
  logic signed [ACC_W-1:0]  acc;
  logic signed [CORR_W-1:0] corr;
  logic                     neg_r;

  // Divider hookup
  logic                 div_neg;
  logic [DIV_W-1:0]     div_dividend;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quo;
  logic signed [Q_W-1:0] q_s;

  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;

  logic signed [ERR_W-1:0]   err_c;
  logic signed [SUM_W:0]     esum_c;
  logic signed [ANG_W-1:0]   head_c;
  logic signed [CORR_W-1:0]  corr_c;
  logic [PWM_W-1:0]          left_c, right_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain        <= PROP_RESET;
      integral_gain    <= INTEG_RESET;
      deriv_gain       <= DERIV_RESET;
      speed_to_degrees <= S2D_RESET;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_PROP:  prop_gain        <= wr_data;
        REG_INTEG: integral_gain    <= wr_data;
        REG_DERIV: deriv_gain       <= wr_data;
        REG_S2D:   speed_to_degrees <= wr_data;
        default: ;
      endcase
    end
  end

  // Shared 33x17 signed multiplier, registered
  always_comb begin
    case (cmd.mul_sel)
      MUL_GYRO: begin
        ma = $signed({1'b0, dt_r});
        mb = MB_W'(rate_r);
      end
      MUL_ENC: begin
        ma = MA_W'(diff_r);
        mb = $signed({1'b0, speed_to_degrees});
      end
      MUL_PROP: begin
        ma = MA_W'(err_r);
        mb = $signed({1'b0, prop_gain});
      end
      MUL_INTEG: begin
        ma = MA_W'(error_sum);
        mb = $signed({1'b0, integral_gain});
      end
      MUL_DERIV: begin
        ma = MA_W'(deriv_r);
        mb = $signed({1'b0, deriv_gain});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Divider operand: magnitude, with rounding bias for the heading blend
  always_comb begin
    logic signed [DIV_W-1:0] p;
    logic signed [NUM_W-1:0] m;
    p = '0;
    m = '0;
    case (cmd.div_sel)
      DIV_GYRO: begin
        p            = $signed({prod[GPROD_W-1:0], 4'b0000});
        div_neg      = p[DIV_W-1];
        div_dividend = div_neg ? DIV_W'(-p) : DIV_W'(p);
      end
      DIV_HEAD: begin
        div_neg      = num[NUM_W-1];
        m            = div_neg ? -num : num;
        div_dividend = DIV_W'(m) + DIV_W'(HEAD_DIV / 2);
      end
      default: begin
        div_neg      = 1'b0;
        div_dividend = '0;
      end
    endcase
  end

  hfps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .sel      (cmd.div_sel),
    .dividend (div_dividend),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign status.div_done = div_done;

  always_comb begin
    logic signed [Q_W-1:0] qm;
    qm  = $signed({1'b0, div_quo[Q_W-2:0]});
    q_s = neg_r ? -qm : qm;
  end

  // Fused heading saturates to 24 bits
  always_comb begin
    if (q_s > FUSE_MAX)      head_c = ANG_MAX;
    else if (q_s < FUSE_MIN) head_c = ANG_MIN;
    else                     head_c = q_s[ANG_W-1:0];
  end

  assign err_c  = ERR_W'(target_r) - ERR_W'(yaw);
  assign esum_c = (SUM_W + 1)'(error_sum) + (SUM_W + 1)'(err_c);

  // Round the PID sum by 2^16, ties away from zero
  always_comb begin
    logic [ACC_W-1:0]  mag;
    logic [ACC_W-1:0]  rnd;
    logic signed [CORR_W-1:0] cm;
    mag    = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    rnd    = mag + ACC_W'(1 << (FRAC_W - 1));
    cm     = $signed({1'b0, rnd[ACC_W-1:FRAC_W]});
    corr_c = acc[ACC_W-1] ? -cm : cm;
  end

  always_comb begin
    logic signed [DRV_W-1:0] l, r;
    l = $signed(DRV_W'({1'b0, lin_r})) - DRV_W'(corr);
    r = $signed(DRV_W'({1'b0, rin_r})) + DRV_W'(corr);
    if (l < 0)            left_c = '0;
    else if (l > PWM_TOP) left_c = PWM_TOP[PWM_W-1:0];
    else                  left_c = l[PWM_W-1:0];
    if (r < 0)            right_c = '0;
    else if (r > PWM_TOP) right_c = PWM_TOP[PWM_W-1:0];
    else                  right_c = r[PWM_W-1:0];
  end

  // Persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw       <= '0;
      prev_time <= '0;
      error_sum <= '0;
      prev_err  <= '0;
    end else begin
      if (cmd.accept) prev_time <= time_ms;
      if (cmd.head_load) yaw <= head_c;
      if (cmd.pid_load) begin
        prev_err <= err_c;
        if (esum_c[SUM_W] != esum_c[SUM_W-1])
          error_sum <= esum_c[SUM_W] ? SUM_MIN : SUM_MAX;
        else
          error_sum <= esum_c[SUM_W-1:0];
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rate_r   <= gyro_rate_raw;
      dt_r     <= time_ms - prev_time;
      diff_r   <= DIFF_W'(speed_right) - DIFF_W'(speed_left);
      target_r <= target_heading;
      lin_r    <= left_drive_in;
      rin_r    <= right_drive_in;
    end
    if (cmd.mul_en) prod <= ma * mb;
    if (cmd.div_start) neg_r <= div_neg;
    if (cmd.ga_load) ga <= GA_W'(yaw) + GA_W'(q_s);
    if (cmd.num_load)
      num <= (NUM_W'(ga) <<< 5) + (NUM_W'(ga) <<< 4) + NUM_W'(ga)
             + NUM_W'($signed(prod[ENC_W-1:0]));
    if (cmd.pid_load) begin
      err_r   <= err_c;
      deriv_r <= DER_W'(err_c) - DER_W'(prev_err);
    end
    if (cmd.acc_clr) acc <= ACC_W'(prod);
    else if (cmd.acc_add) acc <= acc + ACC_W'(prod);
    if (cmd.corr_load) corr <= corr_c;
    if (cmd.out_load) begin
      heading     <= yaw;
      left_drive  <= left_c;
      right_drive <= right_c;
    end
  end

endmodule

// ===== src/hfps_ctrl.sv =====
// Controller: sequences one tick through the datapath and runs the handshakes.
module hfps_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hfps_pkg::ctrl_cmd_t  cmd,
  input  hfps_pkg::dp_status_t status
);
  import hfps_pkg::*;

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001,
    ST_MGY  = 16'h0002,
    ST_DG0  = 16'h0004,
    ST_DGW  = 16'h0008,
    ST_GA   = 16'h0010,
    ST_NUM  = 16'h0020,
    ST_DH0  = 16'h0040,
    ST_DHW  = 16'h0080,
    ST_HEAD = 16'h0100,
    ST_PID  = 16'h0200,
    ST_MP   = 16'h0400,
    ST_MI   = 16'h0800,
    ST_MD   = 16'h1000,
    ST_MACC = 16'h2000,
    ST_CORR = 16'h4000,
    ST_OUT  = 16'h8000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_MGY;
        end
      end
      ST_MGY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GYRO;
        state_next  = ST_DG0;
      end
      ST_DG0: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_GYRO;
        state_next    = ST_DGW;
      end
      ST_DGW: begin
        if (status.div_done) state_next = ST_GA;
      end
      ST_GA: begin
        cmd.ga_load = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ENC;
        state_next  = ST_NUM;
      end
      ST_NUM: begin
        cmd.num_load = 1'b1;
        state_next   = ST_DH0;
      end
      ST_DH0: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_HEAD;
        state_next    = ST_DHW;
      end
      ST_DHW: begin
        cmd.div_sel = DIV_HEAD;
        if (status.div_done) state_next = ST_HEAD;
      end
      ST_HEAD: begin
        cmd.head_load = 1'b1;
        state_next    = ST_PID;
      end
      ST_PID: begin
        cmd.pid_load = 1'b1;
        state_next   = ST_MP;
      end
      ST_MP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_PROP;
        state_next  = ST_MI;
      end
      ST_MI: begin
        cmd.acc_clr = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_INTEG;
        state_next  = ST_MD;
      end
      ST_MD: begin
        cmd.acc_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DERIV;
        state_next  = ST_MACC;
      end
      ST_MACC: begin
        cmd.acc_add = 1'b1;
        state_next  = ST_CORR;
      end
      ST_CORR: begin
        cmd.corr_load = 1'b1;
        state_next    = ST_OUT;
      end
      ST_OUT: begin
        // hold the finished item until the output register frees up
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

// ===== src/heading_fusion_pid_steering.sv =====
// Heading fusion and PID steering correction: top level.
// An item runs through the controller states from acceptance to its result in the output
// register; the next item is accepted on the cycle after the result is loaded, so items
// do not overlap, and a stalled output holds off the next one. Two divider passes divide the
// gyro step by 1025 and the heading blend by 50 in four 13-bit digits, a multiply per digit.
// Synchronous reset clears yaw, timestamp, integral and previous error, and loads gains.
module heading_fusion_pid_steering (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [hfps_pkg::RATE_W-1:0]   gyro_rate_raw,
  input  logic [hfps_pkg::TIME_W-1:0]          time_ms,
  input  logic signed [hfps_pkg::SPEED_W-1:0]  speed_left,
  input  logic signed [hfps_pkg::SPEED_W-1:0]  speed_right,
  input  logic signed [hfps_pkg::ANG_W-1:0]    target_heading,
  input  logic [hfps_pkg::PWM_W-1:0]           left_drive_in,
  input  logic [hfps_pkg::PWM_W-1:0]           right_drive_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [hfps_pkg::ANG_W-1:0]    heading,
  output logic [hfps_pkg::PWM_W-1:0]           left_drive,
  output logic [hfps_pkg::PWM_W-1:0]           right_drive,
  input  logic                                 wr_en,
  input  logic [hfps_pkg::REG_IDX_W-1:0]       wr_index,
  input  logic [hfps_pkg::GAIN_W-1:0]          wr_data
);
  import hfps_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  hfps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  hfps_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .gyro_rate_raw  (gyro_rate_raw),
    .time_ms        (time_ms),
    .speed_left     (speed_left),
    .speed_right    (speed_right),
    .target_heading (target_heading),
    .left_drive_in  (left_drive_in),
    .right_drive_in (right_drive_in),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .heading        (heading),
    .left_drive     (left_drive),
    .right_drive    (right_drive)
  );

endmodule
